FILE: hw/rtl/afod_pkg.sv
// Shared types and constants for the face orientation debounce block.
// Used by afod_axis_lane, afod_merge and the top level; no dependencies.
package afod_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;   // |-32768| = 32768 still fits unsigned
    localparam int DELTA_W  = 16;   // |a - b| <= 65535
    localparam int CHANGE_W = 18;   // sum of three deltas
    localparam int FACE_W   = 3;
    localparam int COUNT_W  = 8;

    localparam int FACE_THR_W   = 15;
    localparam int MOTION_THR_W = 18;
    localparam int CONFIRM_W    = 8;
    localparam int CFG_DATA_W   = 18;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FACE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM    = 2'd2;

    localparam logic [FACE_THR_W-1:0]   FACE_THR_RST   = 15'd11468;
    localparam logic [MOTION_THR_W-1:0] MOTION_THR_RST = 18'd4915;
    localparam logic [CONFIRM_W-1:0]    CONFIRM_RST    = 8'd3;

    // face codes
    localparam logic [FACE_W-1:0] FACE_NONE  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd5;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic               neg;
        logic [DELTA_W-1:0] delta;
    } lane_res_t;

    typedef struct packed {
        logic [FACE_THR_W-1:0]   face_thr;
        logic [MOTION_THR_W-1:0] motion_thr;
        logic [CONFIRM_W-1:0]    confirm;
    } cfg_t;

endpackage

FILE: hw/rtl/accel_face_orientation_debounce.sv
// Top level of the face orientation debounce block: config registers,
// three axis lanes and the merge stage. Depends on afod_pkg, afod_axis_lane, afod_merge.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_accel_x, s_accel_y, s_accel_z
//   m_        out        m_valid / m_ready     m_face_now, m_moving, m_face_changed,
//                                              m_reported_face
//   cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// One request per cycle sustained while m_ready is high. A request reaches m_valid
// through stage one, the lane register, and stage two, the merge/output register,
// so a new request is taken while a finished result waits. Debounce state updates as a
// request enters the output register. Reset (synchronous, aresetn low) restores
// register defaults and clears history, candidate, count and reported face.
module accel_face_orientation_debounce (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [afod_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [afod_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [afod_pkg::SAMPLE_W-1:0]   s_accel_x,
    input  logic signed [afod_pkg::SAMPLE_W-1:0]   s_accel_y,
    input  logic signed [afod_pkg::SAMPLE_W-1:0]   s_accel_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [afod_pkg::FACE_W-1:0]            m_face_now,
    output logic                                   m_moving,
    output logic                                   m_face_changed,
    output logic [afod_pkg::FACE_W-1:0]            m_reported_face
);

    afod_pkg::cfg_t      cfg_reg;
    logic                lane_valid_reg;
    logic                merge_ready;
    logic                load;
    afod_pkg::lane_res_t res_x, res_y, res_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.face_thr   <= afod_pkg::FACE_THR_RST;
            cfg_reg.motion_thr <= afod_pkg::MOTION_THR_RST;
            cfg_reg.confirm    <= afod_pkg::CONFIRM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                afod_pkg::REG_FACE_THR: begin
                    cfg_reg.face_thr <= cfg_wdata[afod_pkg::FACE_THR_W-1:0];
                end
                afod_pkg::REG_MOTION_THR: begin
                    cfg_reg.motion_thr <= cfg_wdata[afod_pkg::MOTION_THR_W-1:0];
                end
                afod_pkg::REG_CONFIRM: begin
                    cfg_reg.confirm <= cfg_wdata[afod_pkg::CONFIRM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !lane_valid_reg || merge_ready;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
        end else if (s_ready) begin
            lane_valid_reg <= s_valid;
        end
    end

    afod_axis_lane u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .sample  (s_accel_x),
        .res     (res_x)
    );

    afod_axis_lane u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .sample  (s_accel_y),
        .res     (res_y)
    );

    afod_axis_lane u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .sample  (s_accel_z),
        .res     (res_z)
    );

    afod_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (lane_valid_reg),
        .in_ready        (merge_ready),
        .lane_x          (res_x),
        .lane_y          (res_y),
        .lane_z          (res_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_face_now      (m_face_now),
        .m_moving        (m_moving),
        .m_face_changed  (m_face_changed),
        .m_reported_face (m_reported_face)
    );

    // a lane result never drops while the merge stage is blocked
    a_lane_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid_reg && !merge_ready) |=> lane_valid_reg)
        else $error("lane stage lost a request");

    // the input side only takes a request when the lane stage can move on
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && lane_valid_reg) |-> merge_ready)
        else $error("lane stage overwritten");

    // a blocked output stalls the lane stage as well
    a_stall_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && lane_valid_reg) |-> !s_ready)
        else $error("ready asserted with both stages full");

endmodule

FILE: hw/rtl/afod_axis_lane.sv
// One axis lane: magnitude, sign and absolute change against the previous sample.
// Depends on afod_pkg.
module afod_axis_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic signed [afod_pkg::SAMPLE_W-1:0] sample,
    output afod_pkg::lane_res_t                 res
);

    logic signed [afod_pkg::SAMPLE_W-1:0] prev_reg;
    afod_pkg::lane_res_t                  res_reg;
    afod_pkg::lane_res_t                  res_next;
    logic signed [afod_pkg::SAMPLE_W:0]   diff;
    logic signed [afod_pkg::SAMPLE_W:0]   sample_ext;

    always_comb begin
        sample_ext = {sample[afod_pkg::SAMPLE_W-1], sample};
        diff       = sample_ext - {prev_reg[afod_pkg::SAMPLE_W-1], prev_reg};
        res_next.neg   = sample[afod_pkg::SAMPLE_W-1];
        res_next.mag   = sample[afod_pkg::SAMPLE_W-1] ?
                         afod_pkg::MAG_W'(-sample_ext) : afod_pkg::MAG_W'(sample_ext);
        res_next.delta = diff[afod_pkg::SAMPLE_W] ?
                         afod_pkg::DELTA_W'(-diff) : afod_pkg::DELTA_W'(diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (load) begin
            prev_reg <= sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: hw/rtl/afod_merge.sv
// Merge stage: face vote across the three lanes, motion sum, debounce, output register.
// Depends on afod_pkg.
module afod_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  afod_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  afod_pkg::lane_res_t               lane_x,
    input  afod_pkg::lane_res_t               lane_y,
    input  afod_pkg::lane_res_t               lane_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [afod_pkg::FACE_W-1:0]       m_face_now,
    output logic                              m_moving,
    output logic                              m_face_changed,
    output logic [afod_pkg::FACE_W-1:0]       m_reported_face
);

    logic                              out_valid_reg;
    logic [afod_pkg::FACE_W-1:0]       face_now_reg;
    logic                              moving_reg;
    logic                              changed_reg;
    logic [afod_pkg::FACE_W-1:0]       reported_reg;

    logic [afod_pkg::FACE_W-1:0]       cand_reg, cand_next;
    logic [afod_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [afod_pkg::FACE_W-1:0]       last_reg, last_next;

    logic [afod_pkg::CHANGE_W-1:0]     change;
    logic                              moving;
    logic [afod_pkg::FACE_W-1:0]       face;
    logic                              changed;
    logic [afod_pkg::MAG_W-1:0]        thr;
    logic                              take;

    assign in_ready = !out_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        thr    = afod_pkg::MAG_W'(cfg.face_thr);
        change = afod_pkg::CHANGE_W'(lane_x.delta) + afod_pkg::CHANGE_W'(lane_y.delta)
               + afod_pkg::CHANGE_W'(lane_z.delta);
        moving = change > cfg.motion_thr;

        // axes tested in order Z, X, Y; winner must be strictly largest
        if (lane_z.mag > thr && lane_z.mag > lane_x.mag && lane_z.mag > lane_y.mag) begin
            face = lane_z.neg ? afod_pkg::FACE_NEG_Z : afod_pkg::FACE_POS_Z;
        end else if (lane_x.mag > thr && lane_x.mag > lane_y.mag
                     && lane_x.mag > lane_z.mag) begin
            face = lane_x.neg ? afod_pkg::FACE_NEG_X : afod_pkg::FACE_POS_X;
        end else if (lane_y.mag > thr && lane_y.mag > lane_x.mag
                     && lane_y.mag > lane_z.mag) begin
            face = lane_y.neg ? afod_pkg::FACE_NEG_Y : afod_pkg::FACE_POS_Y;
        end else begin
            face = afod_pkg::FACE_NONE;
        end

        cand_next  = cand_reg;
        count_next = count_reg;
        if (face == afod_pkg::FACE_NONE) begin
            count_next = '0;
            if (moving) begin
                cand_next = afod_pkg::FACE_NONE;
            end
        end else if (face == cand_reg) begin
            if (count_reg != afod_pkg::COUNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            count_next = afod_pkg::COUNT_W'(1);
            cand_next  = face;
        end

        changed   = (face != afod_pkg::FACE_NONE) && (face != last_reg)
                 && (count_next >= cfg.confirm);
        last_next = changed ? face : last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cand_reg      <= afod_pkg::FACE_NONE;
            count_reg     <= '0;
            last_reg      <= afod_pkg::FACE_NONE;
        end else begin
            if (take) begin
                out_valid_reg <= 1'b1;
                cand_reg      <= cand_next;
                count_reg     <= count_next;
                last_reg      <= last_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            face_now_reg <= face;
            moving_reg   <= moving;
            changed_reg  <= changed;
            reported_reg <= last_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_face_now      = face_now_reg;
    assign m_moving        = moving_reg;
    assign m_face_changed  = changed_reg;
    assign m_reported_face = reported_reg;

    // a running count always belongs to a real candidate
    a_count_has_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (cand_reg != afod_pkg::FACE_NONE))
        else $error("confirm count without candidate");

    // reported face moves only together with a change request
    a_last_moves_on_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (last_reg != $past(last_reg)))
            |-> (out_valid_reg && changed_reg))
        else $error("reported face changed silently");

    // a change request reports the face just seen
    a_change_matches_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && changed_reg)
            |-> (reported_reg == face_now_reg && face_now_reg != afod_pkg::FACE_NONE))
        else $error("change request with wrong face");

endmodule
